@@ src/urxf_pkg.sv @@
// ----------------------------------------------------------------------------
// UART receive framer package
// Shared types, sizes and codes of the idle timeout framer.
// ----------------------------------------------------------------------------
package urxf_pkg;

   localparam int FRAME_BYTES  = 128;
   localparam int QUEUE_FRAMES = 4;
   localparam int SLOTS        = QUEUE_FRAMES + 1;
   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FILL_W       = $clog2(FRAME_BYTES + 1);
   localparam int OFF_W        = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int ADDR_W       = $clog2(SLOTS * FRAME_BYTES);
   localparam int QCNT_W       = $clog2(QUEUE_FRAMES + 1);
   localparam int CMDQ_DEPTH   = 2;
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W    = $clog2(RSP_DEPTH + 1);

   localparam logic [15:0] IDLE_TICKS_RESET  = 16'd300;
   localparam logic        SHARED_LINE_RESET = 1'b1;

   localparam logic [2:0] OP_BYTE     = 3'd0;
   localparam logic [2:0] OP_TICK     = 3'd1;
   localparam logic [2:0] OP_TX_BEGIN = 3'd2;
   localparam logic [2:0] OP_TX_END   = 3'd3;
   localparam logic [2:0] OP_REARM    = 3'd4;
   localparam logic [2:0] OP_FETCH    = 3'd5;

   localparam logic REG_SHARED_LINE = 1'b0;
   localparam logic REG_IDLE_TICKS  = 1'b1;

   typedef enum logic [2:0] {
      CMD_BYTE,
      CMD_TICK,
      CMD_TX_BEGIN,
      CMD_TX_END,
      CMD_REARM,
      CMD_FETCH,
      CMD_NONE
   } cmd_type;

   typedef enum logic [1:0] {
      RX_IDLE = 2'd0,
      RX_RECV = 2'd1,
      RX_DONE = 2'd2
   } rx_state_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic       accepted;
      logic       frame_closed;
      logic       overwrote_oldest;
      logic       out_valid;
      logic [7:0] out_byte;
      logic       out_last;
      logic [7:0] out_length;
      logic [2:0] frames_queued;
      logic [1:0] rx_state;
      logic       tx_busy;
   } rsp_item_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
   } cmd_item_type;

   typedef struct packed {
      logic        shared_line;
      logic [15:0] idle_ticks;
   } cfg_type;

endpackage

@@ src/uart_rx_idle_timeout_framer_core.sv @@
// ----------------------------------------------------------------------------
// UART receive idle timeout framer
// Collects received bytes into frames closed by an idle timer or a full
// buffer, queues closed frames and returns them byte by byte on fetch.
//
//   Channel   Signals                                   Direction
//   req       push, full, req_item                      in
//   rsp       empty, pop, rsp_item                      out
//   csr       psel, penable, pwrite, paddr, pwdata,     in/out
//             prdata, pready
//
// One item per cycle is sustained while neither queue stalls. A result goes
// through the command queue, the execute stage with the frame store read and
// the result queue to the result ports. The command queue holds two items and
// the result queue four; execution waits while the result queue and the
// execute stage together hold four results, so either side can stall without
// stopping the other. Synchronous reset clears control state, not the store.
// ----------------------------------------------------------------------------
module uart_rx_idle_timeout_framer_core
   import urxf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic                 shared_line_ff, shared_line_in;
   logic [15:0]          idle_ticks_ff, idle_ticks_in;
   logic                 csr_write;
   logic                 csr_index;
   cfg_type              cfg;
   logic                 cmd_valid;
   cmd_item_type         cmd_item;
   logic                 cmd_pop;
   logic [RSP_CNT_W-1:0] rsp_count;
   logic                 rsp_push;
   rsp_item_type         rsp_new;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      shared_line_in = shared_line_ff;
      idle_ticks_in  = idle_ticks_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SHARED_LINE: shared_line_in = pwdata[0];
            REG_IDLE_TICKS:  idle_ticks_in  = pwdata[15:0];
            default:         shared_line_in = shared_line_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SHARED_LINE: prdata = {31'd0, shared_line_ff};
         REG_IDLE_TICKS:  prdata = {16'd0, idle_ticks_ff};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_line_ff <= SHARED_LINE_RESET;
         idle_ticks_ff  <= IDLE_TICKS_RESET;
      end else begin
         shared_line_ff <= shared_line_in;
         idle_ticks_ff  <= idle_ticks_in;
      end
   end

   assign cfg.shared_line = shared_line_ff;
   assign cfg.idle_ticks  = idle_ticks_ff;

   urxf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop)
   );

   urxf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_new)
   );

   urxf_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .rsp_push    (rsp_push),
      .rsp_in_item (rsp_new),
      .rsp_count   (rsp_count),
      .empty       (empty),
      .pop         (pop),
      .rsp_item    (rsp_item)
   );

endmodule

@@ src/urxf_front.sv @@
// ----------------------------------------------------------------------------
// UART receive framer front end
// Accepts items, decodes the operation code and queues the commands.
// ----------------------------------------------------------------------------
module urxf_front
   import urxf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         cmd_valid,
   output cmd_item_type cmd_item,
   input  logic         cmd_pop
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_item_type             entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   cmd_item_type             decoded;
   logic                     do_push;
   logic                     do_pop;

   always_comb begin
      decoded.data_byte = req_item.data_byte;
      case (req_item.op)
         OP_BYTE:     decoded.cmd = CMD_BYTE;
         OP_TICK:     decoded.cmd = CMD_TICK;
         OP_TX_BEGIN: decoded.cmd = CMD_TX_BEGIN;
         OP_TX_END:   decoded.cmd = CMD_TX_END;
         OP_REARM:    decoded.cmd = CMD_REARM;
         OP_FETCH:    decoded.cmd = CMD_FETCH;
         default:     decoded.cmd = CMD_NONE;
      endcase
   end

   assign full      = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ src/urxf_back.sv @@
// ----------------------------------------------------------------------------
// UART receive framer back end
// Holds the framing state, the frame store and the timer, executes one
// command per cycle while the result queue has room and assembles the
// result after the store read.
module urxf_back
   import urxf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 cmd_valid,
   input  cmd_item_type         cmd_item,
   output logic                 cmd_pop,
   input  logic [RSP_CNT_W-1:0] rsp_count,
   output logic                 rsp_push,
   output rsp_item_type         rsp_item
);

   logic [7:0]        mem [SLOTS * FRAME_BYTES];
   logic [FILL_W-1:0] len_ff [SLOTS];

   logic [FILL_W-1:0] fill_ff, fill_in;
   rx_state_type      rx_ff, rx_in;
   logic              tx_busy_ff, tx_busy_in;
   logic [15:0]       idle_count_ff, idle_count_in;
   logic              idle_run_ff, idle_run_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] qcount_ff, qcount_in;
   logic [OFF_W-1:0]  rd_off_ff, rd_off_in;
   logic              s2_valid_ff;
   rsp_item_type      s2_ff, s2_in;
   logic [7:0]        rd_data_ff;

   logic              exec;
   logic [15:0]       limit;
   logic [16:0]       tick_sum;
   logic              tick_hit;
   logic              refuse;
   logic              buf_full;
   logic              close_go;
   logic              store_go;
   logic              fetch_go;
   logic              lost;
   logic              fetch_last;
   logic [FILL_W-1:0] head_len;
   logic [SLOT_W-1:0] head_inc;
   logic [SLOT_W-1:0] tail_inc;
   logic [SLOT_W-1:0] wr_slot;
   logic [OFF_W-1:0]  wr_off;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      slot_inc = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   assign exec     = cmd_valid && ((RSP_CNT_W + 1)'(rsp_count) + (RSP_CNT_W + 1)'(s2_valid_ff)
                                   < (RSP_CNT_W + 1)'(RSP_DEPTH));
   assign cmd_pop  = exec;
   assign head_inc = slot_inc(head_ff);
   assign tail_inc = slot_inc(tail_ff);
   assign head_len = len_ff[head_ff];

   always_comb begin
      limit      = (cfg.idle_ticks == '0) ? 16'd1 : cfg.idle_ticks;
      tick_sum   = {1'b0, idle_count_ff} + 17'd1;
      tick_hit   = (tick_sum >= {1'b0, limit});
      refuse     = (cfg.shared_line && tx_busy_ff) || (rx_ff != RX_RECV);
      buf_full   = (fill_ff == FILL_W'(FRAME_BYTES));
      fetch_last = ((FILL_W + 1)'(rd_off_ff) + 1'b1) >= (FILL_W + 1)'(head_len);
      close_go   = 1'b0;
      store_go   = 1'b0;
      fetch_go   = 1'b0;
      if (exec) begin
         case (cmd_item.cmd)
            CMD_BYTE: begin
               if (!refuse) begin
                  close_go = buf_full;
                  store_go = !(buf_full && cfg.shared_line);
               end
            end
            CMD_TICK: begin
               close_go = idle_run_ff && tick_hit && (fill_ff != '0);
            end
            CMD_FETCH: begin
               fetch_go = (qcount_ff != '0);
            end
            default: begin
               close_go = 1'b0;
            end
         endcase
      end
      lost = close_go && (qcount_ff == QCNT_W'(QUEUE_FRAMES));
   end

   always_comb begin
      rx_in = rx_ff;
      if (exec) begin
         case (cmd_item.cmd)
            CMD_REARM: begin
               rx_in = RX_RECV;
            end
            CMD_BYTE, CMD_TICK: begin
               if (close_go) begin
                  rx_in = cfg.shared_line ? RX_DONE : RX_RECV;
               end
            end
            default: begin
               rx_in = rx_ff;
            end
         endcase
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      tx_busy_in    = tx_busy_ff;
      idle_count_in = idle_count_ff;
      idle_run_in   = idle_run_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      qcount_in     = qcount_ff;
      rd_off_in     = rd_off_ff;
      wr_slot       = close_go ? tail_inc : tail_ff;
      wr_off        = close_go ? '0 : fill_ff[OFF_W-1:0];

      if (close_go) begin
         tail_in       = tail_inc;
         fill_in       = '0;
         idle_run_in   = 1'b0;
         idle_count_in = '0;
         if (lost) begin
            head_in   = head_inc;
            rd_off_in = '0;
         end else begin
            qcount_in = qcount_ff + 1'b1;
         end
      end
      if (store_go) begin
         fill_in       = close_go ? FILL_W'(1) : fill_ff + 1'b1;
         idle_count_in = '0;
         idle_run_in   = 1'b1;
      end

      if (exec) begin
         case (cmd_item.cmd)
            CMD_TICK: begin
               if (idle_run_ff && !close_go) begin
                  if (tick_hit) begin
                     idle_run_in   = 1'b0;
                     idle_count_in = '0;
                  end else begin
                     idle_count_in = tick_sum[15:0];
                  end
               end
            end
            CMD_TX_BEGIN: begin
               tx_busy_in = 1'b1;
            end
            CMD_TX_END: begin
               tx_busy_in = 1'b0;
            end
            CMD_REARM: begin
               fill_in       = '0;
               idle_run_in   = 1'b0;
               idle_count_in = '0;
            end
            CMD_FETCH: begin
               if (fetch_go) begin
                  if (fetch_last) begin
                     head_in   = head_inc;
                     qcount_in = qcount_ff - 1'b1;
                     rd_off_in = '0;
                  end else begin
                     rd_off_in = rd_off_ff + 1'b1;
                  end
               end
            end
            default: begin
               tx_busy_in = tx_busy_ff;
            end
         endcase
      end
   end

   assign wr_addr = ADDR_W'(wr_slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(wr_off);
   assign rd_addr = ADDR_W'(head_ff) * ADDR_W'(FRAME_BYTES) + ADDR_W'(rd_off_ff);

   always_comb begin
      s2_in.accepted         = store_go;
      s2_in.frame_closed     = close_go;
      s2_in.overwrote_oldest = lost;
      s2_in.out_valid        = fetch_go;
      s2_in.out_byte         = '0;
      s2_in.out_last         = fetch_go && fetch_last;
      s2_in.out_length       = fetch_go ? 8'(head_len) : 8'd0;
      s2_in.frames_queued    = 3'(qcount_in);
      s2_in.rx_state         = 2'(rx_in);
      s2_in.tx_busy          = tx_busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rx_ff         <= RX_IDLE;
         tx_busy_ff    <= 1'b0;
         idle_count_ff <= '0;
         idle_run_ff   <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         qcount_ff     <= '0;
         rd_off_ff     <= '0;
         s2_valid_ff   <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rx_ff         <= rx_in;
         tx_busy_ff    <= tx_busy_in;
         idle_count_ff <= idle_count_in;
         idle_run_ff   <= idle_run_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         qcount_ff     <= qcount_in;
         rd_off_ff     <= rd_off_in;
         s2_valid_ff   <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         s2_ff <= s2_in;
      end
      if (close_go) begin
         len_ff[tail_ff] <= fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store_go) begin
         mem[wr_addr] <= cmd_item.data_byte;
      end
      if (exec) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      rsp_item          = s2_ff;
      rsp_item.out_byte = s2_ff.out_valid ? rd_data_ff : 8'd0;
   end

   assign rsp_push = s2_valid_ff;

endmodule

@@ src/urxf_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// UART receive framer result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module urxf_rsp_queue
   import urxf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_push,
   input  rsp_item_type         rsp_in_item,
   output logic [RSP_CNT_W-1:0] rsp_count,
   output logic                 empty,
   input  logic                 pop,
   output rsp_item_type         rsp_item
);

   rsp_item_type           entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign empty     = (count_ff == '0);
   assign rsp_count = count_ff;
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (rsp_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !rsp_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         entry_ff[wr_ptr_ff] <= rsp_in_item;
      end
   end

endmodule
